// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the base-85 codec RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define B85_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define B85_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define B85_ASSERT_IMP(lbl, ante, cons, msg)
`define B85_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/b85_pkg.sv =====
// Shared types and constants of the base-85 stream codec.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package b85_pkg;

  localparam logic [7:0]  CHAR_OFFSET    = 8'd33;
  localparam logic [7:0]  CHAR_MAX_VALID = 8'd117;
  localparam logic [7:0]  DIGIT_BASE     = 8'd85;
  localparam logic [31:0] RECIP_85       = 32'h0303_0303;
  localparam logic [2:0]  ENC_CHUNK      = 3'd4;
  localparam logic [2:0]  DEC_CHUNK      = 3'd5;

  typedef enum logic [2:0] {
    JOB_ENC = 3'b001,
    JOB_DEC = 3'b010,
    JOB_MIS = 3'b100
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [31:0] word;
    logic        bad;
    logic        last;
  } job_t;

  typedef enum logic [2:0] {
    CV_IDLE = 3'b001,
    CV_MUL  = 3'b010,
    CV_FIX  = 3'b100
  } conv_state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/b85_if.sv =====
// Channel interfaces of the base-85 codec: input, result and mode write.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface b85_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_in;
  modport source (output valid, in_byte, last_in, input ready);
  modport sink   (input valid, in_byte, last_in, output ready);
endinterface

interface b85_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       buffer_end;
  logic       bad_char;
  logic       misaligned;
  modport source (output valid, out_byte, run_last, buffer_end, bad_char, misaligned,
                  input ready);
  modport sink   (input valid, out_byte, run_last, buffer_end, bad_char, misaligned,
                  output ready);
endinterface

interface b85_cfg_if;
  logic valid;
  logic ready;
  logic mode;
  modport source (output valid, mode, input ready);
  modport sink   (input valid, mode, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/b85_front.sv =====
// Front end: mode register, chunk gathering and job classification.
// Depends on b85_pkg and b85_if.
`timescale 1ns / 1ps
`default_nettype none
module b85_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  b85_in_if.sink             in_ch,
  b85_cfg_if.sink            cfg_ch,
  output b85_pkg::job_t      job,
  output logic               job_valid,
  input  wire logic          job_ready
);

  logic        mode_r;
  logic [31:0] acc_r, acc_nxt;
  logic [2:0]  pos_r, pos_nxt;
  logic        bad_r, bad_nxt;
  logic        accept;
  logic        chunk_done;
  logic [7:0]  digit;

  assign in_ch.ready  = job_ready;
  assign cfg_ch.ready = 1'b1;
  assign accept       = in_ch.valid && job_ready;
  assign digit        = in_ch.in_byte - b85_pkg::CHAR_OFFSET;

  always_comb begin
    if (mode_r) begin
      acc_nxt = acc_r * 32'd85 + {24'b0, digit};
      bad_nxt = bad_r || (in_ch.in_byte < b85_pkg::CHAR_OFFSET) ||
                (in_ch.in_byte > b85_pkg::CHAR_MAX_VALID);
    end else begin
      acc_nxt = {acc_r[23:0], in_ch.in_byte};
      bad_nxt = 1'b0;
    end
    pos_nxt    = pos_r + 3'd1;
    chunk_done = pos_nxt == (mode_r ? b85_pkg::DEC_CHUNK : b85_pkg::ENC_CHUNK);
    job_valid  = accept && (chunk_done || in_ch.last_in);
    if (chunk_done) begin
      job.kind = mode_r ? b85_pkg::JOB_DEC : b85_pkg::JOB_ENC;
    end else begin
      job.kind = b85_pkg::JOB_MIS;
    end
    job.word = acc_nxt;
    job.bad  = bad_nxt;
    job.last = in_ch.last_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      acc_r  <= '0;
      pos_r  <= '0;
      bad_r  <= 1'b0;
    end else if (cfg_ch.valid) begin
      mode_r <= cfg_ch.mode;
      acc_r  <= '0;
      pos_r  <= '0;
      bad_r  <= 1'b0;
    end else if (accept) begin
      if (job_valid) begin
        acc_r <= '0;
        pos_r <= '0;
        bad_r <= 1'b0;
      end else begin
        acc_r <= acc_nxt;
        pos_r <= pos_nxt;
        bad_r <= bad_nxt;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/b85_queue.sv =====
// Job queue between front and back end.
// Depends on b85_pkg.
`timescale 1ns / 1ps
`default_nettype none
module b85_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire b85_pkg::job_t  push_data,
  input  wire logic           push_valid,
  output logic                push_ready,
  output b85_pkg::job_t       pop_data,
  output logic                pop_valid,
  input  wire logic           pop_ready
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  b85_pkg::job_t  mem_r [DEPTH];
  logic [PW-1:0]  wr_r, rd_r;
  logic [CW-1:0]  cnt_r;
  logic           push, pop;

  assign push_ready = cnt_r != CW'(DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_data   = mem_r[rd_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/b85_back.sv =====
// Back end: base-85 digit converter and result burst register.
// Depends on b85_pkg and b85_if.
`timescale 1ns / 1ps
`default_nettype none
module b85_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire b85_pkg::job_t  job,
  input  wire logic           job_valid,
  output logic                job_ready,
  b85_out_if.source           out_ch
);

  b85_pkg::conv_state_t cv_state_r;
  logic [31:0] cv_w_r;
  logic [25:0] cv_q_r;
  logic [1:0]  cv_n_r;
  logic        cv_last_r;
  logic [7:0]  cv_chars_r [3];

  logic        em_valid_r;
  logic [7:0]  em_chars_r [5];
  logic [2:0]  em_cnt_r;
  logic        em_last_r, em_bad_r, em_mis_r;

  logic [57:0] prod;
  logic [31:0] prod85, diff;
  logic        fix;
  logic [7:0]  rem, rem_char, q_char;
  logic [25:0] q_fix;
  logic        cv_final, cv_hand, cv_free, is_enc, job_pop;
  logic        em_fire, em_can_load, load_job;

  assign prod     = {26'b0, cv_w_r} * {26'b0, b85_pkg::RECIP_85};
  assign prod85   = {6'b0, cv_q_r} * {24'b0, b85_pkg::DIGIT_BASE};
  assign diff     = cv_w_r - prod85;
  assign fix      = diff[7:0] >= b85_pkg::DIGIT_BASE;
  assign rem      = fix ? diff[7:0] - b85_pkg::DIGIT_BASE : diff[7:0];
  assign q_fix    = cv_q_r + {25'b0, fix};
  assign rem_char = rem + b85_pkg::CHAR_OFFSET;
  assign q_char   = q_fix[7:0] + b85_pkg::CHAR_OFFSET;

  assign em_fire     = out_ch.valid && out_ch.ready;
  assign em_can_load = !em_valid_r || (em_fire && em_cnt_r == 3'd1);

  assign cv_final  = (cv_state_r == b85_pkg::CV_FIX) && (cv_n_r == 2'd3);
  assign cv_hand   = cv_final && em_can_load;
  assign cv_free   = (cv_state_r == b85_pkg::CV_IDLE) || cv_hand;
  assign is_enc    = job.kind == b85_pkg::JOB_ENC;
  assign job_ready = is_enc ? cv_free
                            : ((cv_state_r == b85_pkg::CV_IDLE) && em_can_load);
  assign job_pop   = job_valid && job_ready;
  assign load_job  = job_pop && !is_enc;

  assign out_ch.valid      = em_valid_r;
  assign out_ch.out_byte   = em_chars_r[0];
  assign out_ch.run_last   = em_cnt_r == 3'd1;
  assign out_ch.buffer_end = (em_cnt_r == 3'd1) && em_last_r;
  assign out_ch.bad_char   = em_bad_r;
  assign out_ch.misaligned = em_mis_r;

  // converter control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_state_r <= b85_pkg::CV_IDLE;
    end else begin
      unique case (cv_state_r)
        b85_pkg::CV_IDLE: begin
          if (job_pop && is_enc) begin
            cv_state_r <= b85_pkg::CV_MUL;
          end
        end
        b85_pkg::CV_MUL: begin
          cv_state_r <= b85_pkg::CV_FIX;
        end
        b85_pkg::CV_FIX: begin
          if (!cv_final) begin
            cv_state_r <= b85_pkg::CV_MUL;
          end else if (cv_hand) begin
            cv_state_r <= (job_pop && is_enc) ? b85_pkg::CV_MUL : b85_pkg::CV_IDLE;
          end
        end
        default: begin
          cv_state_r <= b85_pkg::CV_IDLE;
        end
      endcase
    end
  end

  // converter datapath
  always_ff @(posedge clk) begin
    if (job_pop && is_enc) begin
      cv_w_r    <= job.word;
      cv_last_r <= job.last;
      cv_n_r    <= 2'd0;
    end else if (cv_state_r == b85_pkg::CV_MUL) begin
      cv_q_r <= prod[57:32];
    end else if ((cv_state_r == b85_pkg::CV_FIX) && !cv_final) begin
      cv_w_r        <= {6'b0, q_fix};
      cv_n_r        <= cv_n_r + 2'd1;
      cv_chars_r[0] <= rem_char;
      cv_chars_r[1] <= cv_chars_r[0];
      cv_chars_r[2] <= cv_chars_r[1];
    end
  end

  // burst register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      em_valid_r <= 1'b0;
    end else if (cv_hand || load_job) begin
      em_valid_r <= 1'b1;
    end else if (em_fire && em_cnt_r == 3'd1) begin
      em_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cv_hand) begin
      em_chars_r[0] <= q_char;
      em_chars_r[1] <= rem_char;
      em_chars_r[2] <= cv_chars_r[0];
      em_chars_r[3] <= cv_chars_r[1];
      em_chars_r[4] <= cv_chars_r[2];
      em_cnt_r      <= 3'd5;
      em_last_r     <= cv_last_r;
      em_bad_r      <= 1'b0;
      em_mis_r      <= 1'b0;
    end else if (load_job) begin
      if (job.kind == b85_pkg::JOB_MIS) begin
        em_chars_r[0] <= 8'd0;
        em_cnt_r      <= 3'd1;
        em_bad_r      <= 1'b0;
        em_mis_r      <= 1'b1;
      end else begin
        em_chars_r[0] <= job.word[31:24];
        em_chars_r[1] <= job.word[23:16];
        em_chars_r[2] <= job.word[15:8];
        em_chars_r[3] <= job.word[7:0];
        em_cnt_r      <= 3'd4;
        em_bad_r      <= job.bad;
        em_mis_r      <= 1'b0;
      end
      em_last_r <= job.last;
    end else if (em_fire) begin
      em_chars_r[0] <= em_chars_r[1];
      em_chars_r[1] <= em_chars_r[2];
      em_chars_r[2] <= em_chars_r[3];
      em_chars_r[3] <= em_chars_r[4];
      em_cnt_r      <= em_cnt_r - 3'd1;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/base85_stream_codec.sv =====
// Top level of the base-85 stream codec: front end, job queue, back end.
// Depends on b85_pkg, b85_if, b85_front, b85_queue, b85_back, assert_macros.svh.
//
//   channel  dir  beat carries
//   in_ch    in   in_byte, last_in
//   out_ch   out  out_byte, run_last, buffer_end, bad_char, misaligned
//   cfg_ch   in   mode (clears the partial chunk)
//
// The front end takes one input beat per cycle while the queue has room.
// Encode: each chunk passes the shared divide-by-85 unit (multiply, then
// correct, for each of four digits); the five characters leave one per
// cycle while out_ch is ready, and the next chunk converts meanwhile.
// Decode: four result beats per five input beats, one beat per cycle unless out_ch stalls.
// Reset is synchronous; no clearing pass. Either side may stall independently.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module base85_stream_codec #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  b85_in_if.sink      in_ch,
  b85_out_if.source   out_ch,
  b85_cfg_if.sink     cfg_ch
);

  b85_pkg::job_t push_job, pop_job;
  logic          push_valid, push_ready, pop_valid, pop_ready;

  b85_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_ch    (cfg_ch),
    .job       (push_job),
    .job_valid (push_valid),
    .job_ready (push_ready)
  );

  b85_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_data  (push_job),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_data   (pop_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  b85_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (pop_job),
    .job_valid (pop_valid),
    .job_ready (pop_ready),
    .out_ch    (out_ch)
  );

  `B85_ASSERT_IMP(a_mis_shape, out_ch.valid && out_ch.misaligned, out_ch.run_last && out_ch.buffer_end && (out_ch.out_byte == 8'd0) && !out_ch.bad_char, "misaligned beat malformed")
  `B85_ASSERT_IMP(a_end_on_last, out_ch.valid && out_ch.buffer_end, out_ch.run_last, "buffer_end off the final beat")
  `B85_ASSERT_NEXT(a_burst_cont, out_ch.valid && out_ch.ready && !out_ch.run_last, out_ch.valid, "gap inside a result burst")

endmodule
`default_nettype wire
